// ===== hw/rtl/cigar_span_calculator_assert.svh =====
// Assertion macros for the CIGAR span calculator.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef CIGAR_SPAN_CALCULATOR_ASSERT_SVH
`define CIGAR_SPAN_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CSPAN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSPAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cspan_pkg.sv =====
// Shared types, op codes and field widths for the CIGAR span calculator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cspan_pkg;

  localparam int START_BITS     = 32;
  localparam int OP_BITS        = 4;
  localparam int FIELD_LEN_BITS = 28;
  localparam int RESULT_BITS    = 32;

  localparam int DEF_POSITION_BITS = 32;
  localparam int DEF_LENGTH_BITS   = 28;

  // BAM CIGAR op codes
  localparam logic [OP_BITS-1:0] OP_M  = 4'd0;
  localparam logic [OP_BITS-1:0] OP_I  = 4'd1;
  localparam logic [OP_BITS-1:0] OP_D  = 4'd2;
  localparam logic [OP_BITS-1:0] OP_N  = 4'd3;
  localparam logic [OP_BITS-1:0] OP_S  = 4'd4;
  localparam logic [OP_BITS-1:0] OP_H  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_P  = 4'd6;
  localparam logic [OP_BITS-1:0] OP_EQ = 4'd7;
  localparam logic [OP_BITS-1:0] OP_X  = 4'd8;

  typedef struct packed {
    logic [START_BITS-1:0]     start_position;
    logic [OP_BITS-1:0]        op_code;
    logic [FIELD_LEN_BITS-1:0] op_length;
    logic                      first_element;
    logic                      last_element;
  } cspan_in_t;

  typedef struct packed {
    logic [RESULT_BITS-1:0] ref_stop;
    logic [RESULT_BITS-1:0] unclipped_begin;
    logic [RESULT_BITS-1:0] unclipped_end;
  } cspan_out_t;

  // Ops that advance along the reference.
  function automatic logic op_is_ref(input logic [OP_BITS-1:0] op);
    return op inside {OP_M, OP_D, OP_N, OP_EQ, OP_X};
  endfunction

  // Soft and hard clips.
  function automatic logic op_is_clip(input logic [OP_BITS-1:0] op);
    return op inside {OP_S, OP_H};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cigar_span_calculator.sv =====
// Top level of the CIGAR span calculator: accumulator stage plus result stage.
// Depends on cspan_pkg, cspan_accum, cspan_finish and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "cigar_span_calculator_assert.svh"

// CIGAR span calculator. Takes one CIGAR element per request on the in_
// channel; first_element opens a record and latches start_position,
// last_element closes it and yields one out_ request carrying the alignment
// stop, unclipped begin and unclipped end. Elements that are not last give
// no result. Throughput is one element per clock while in_stall is low. The
// accumulator stage (running sums per element) fills the snapshot register
// when a last element is accepted, and the result stage (final adds) then
// loads the output register. A finished record waits in the snapshot, so the
// input keeps flowing while the output register holds a stalled result; in_stall
// rises only when both of those are full and out_stall is high. Positions
// wrap at POSITION_BITS; element lengths are masked to LENGTH_BITS. Clips
// that sit between non-clip ops count toward neither unclipped value; a
// record made only of clips counts every clip as both leading and trailing.
module cigar_span_calculator #(
  parameter int POSITION_BITS = cspan_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = cspan_pkg::DEF_LENGTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cspan_pkg::cspan_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cspan_pkg::cspan_out_t out_data
);
  import cspan_pkg::*;

  logic                     in_accept;
  logic                     snap_valid, snap_take, snap_saw;
  logic [POSITION_BITS-1:0] snap_start, snap_ref, snap_lead, snap_trail;

  // Stall only when the snapshot is full and cannot move on this cycle.
  assign in_stall  = snap_valid && !snap_take;
  assign in_accept = in_valid && !in_stall;

  cspan_accum #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (in_accept),
    .item        (in_data),
    .snap_take   (snap_take),
    .snap_valid  (snap_valid),
    .snap_start  (snap_start),
    .snap_ref    (snap_ref),
    .snap_lead   (snap_lead),
    .snap_trail  (snap_trail),
    .snap_saw    (snap_saw)
  );

  cspan_finish #(
    .POSITION_BITS (POSITION_BITS)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_start (snap_start),
    .snap_ref   (snap_ref),
    .snap_lead  (snap_lead),
    .snap_trail (snap_trail),
    .snap_saw   (snap_saw),
    .snap_take  (snap_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // A closed record always lands in the snapshot register.
  `CSPAN_ASSERT_NEXT(a_last_fills_snap, in_accept && in_data.last_element, snap_valid,
    "accepted last element did not fill the snapshot")

  // A snapshot that is not taken must not be dropped.
  `CSPAN_ASSERT_NEXT(a_snap_held, snap_valid && !snap_take, snap_valid,
    "pending snapshot lost while output was stalled")

  // With nothing behind it, a delivered result must not appear again.
  `CSPAN_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !snap_valid, !out_valid,
    "result repeated after delivery")

endmodule

`default_nettype wire

// ===== hw/rtl/cspan_accum.sv =====
// Per-record accumulators and the end-of-record snapshot register.
// Depends on cspan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cspan_accum #(
  parameter int POSITION_BITS = cspan_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = cspan_pkg::DEF_LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_accept,
  input  cspan_pkg::cspan_in_t     item,
  input  logic                     snap_take,
  output logic                     snap_valid,
  output logic [POSITION_BITS-1:0] snap_start,
  output logic [POSITION_BITS-1:0] snap_ref,
  output logic [POSITION_BITS-1:0] snap_lead,
  output logic [POSITION_BITS-1:0] snap_trail,
  output logic                     snap_saw
);
  import cspan_pkg::*;

  localparam int LEN_KEEP = (LENGTH_BITS < FIELD_LEN_BITS) ? LENGTH_BITS : FIELD_LEN_BITS;
  localparam logic [FIELD_LEN_BITS-1:0] LEN_MASK =
    {FIELD_LEN_BITS{1'b1}} >> (FIELD_LEN_BITS - LEN_KEEP);

  logic [POSITION_BITS-1:0] rec_start_r, ref_sum_r, lead_sum_r, trail_run_r;
  logic                     in_lead_r, saw_ref_r;
  logic [POSITION_BITS-1:0] rec_start_nxt, ref_sum_nxt, lead_sum_nxt, trail_run_nxt;
  logic                     in_lead_nxt, saw_ref_nxt;

  logic                     snap_valid_r, snap_valid_nxt;
  logic [POSITION_BITS-1:0] snap_start_r, snap_ref_r, snap_lead_r, snap_trail_r;
  logic                     snap_saw_r;

  logic [POSITION_BITS-1:0] len_pos;
  logic [POSITION_BITS-1:0] base_ref, base_lead, base_trail;
  logic                     base_in_lead, base_saw;
  logic                     is_clip, is_ref;

  assign len_pos = POSITION_BITS'(item.op_length & LEN_MASK);
  assign is_clip = op_is_clip(item.op_code);
  assign is_ref  = op_is_ref(item.op_code);

  // A first element starts from cleared accumulators.
  always_comb begin
    rec_start_nxt = item.first_element ? POSITION_BITS'(item.start_position) : rec_start_r;
    base_ref      = item.first_element ? '0   : ref_sum_r;
    base_lead     = item.first_element ? '0   : lead_sum_r;
    base_trail    = item.first_element ? '0   : trail_run_r;
    base_in_lead  = item.first_element ? 1'b1 : in_lead_r;
    base_saw      = item.first_element ? 1'b0 : saw_ref_r;

    if (is_clip) begin
      lead_sum_nxt  = base_in_lead ? base_lead + len_pos : base_lead;
      trail_run_nxt = base_trail + len_pos;
      in_lead_nxt   = base_in_lead;
    end else begin
      lead_sum_nxt  = base_lead;
      trail_run_nxt = '0;
      in_lead_nxt   = 1'b0;
    end

    if (is_ref) begin
      ref_sum_nxt = base_ref + len_pos;
      saw_ref_nxt = 1'b1;
    end else begin
      ref_sum_nxt = base_ref;
      saw_ref_nxt = base_saw;
    end

    if (item_accept && item.last_element) begin
      snap_valid_nxt = 1'b1;
    end else if (snap_take) begin
      snap_valid_nxt = 1'b0;
    end else begin
      snap_valid_nxt = snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_start_r  <= '0;
      ref_sum_r    <= '0;
      lead_sum_r   <= '0;
      trail_run_r  <= '0;
      in_lead_r    <= 1'b1;
      saw_ref_r    <= 1'b0;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (item_accept) begin
        rec_start_r <= rec_start_nxt;
        if (item.last_element) begin
          // record done: clear for the next one, start is kept
          ref_sum_r   <= '0;
          lead_sum_r  <= '0;
          trail_run_r <= '0;
          in_lead_r   <= 1'b1;
          saw_ref_r   <= 1'b0;
        end else begin
          ref_sum_r   <= ref_sum_nxt;
          lead_sum_r  <= lead_sum_nxt;
          trail_run_r <= trail_run_nxt;
          in_lead_r   <= in_lead_nxt;
          saw_ref_r   <= saw_ref_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && item.last_element) begin
      snap_start_r <= rec_start_nxt;
      snap_ref_r   <= ref_sum_nxt;
      snap_lead_r  <= lead_sum_nxt;
      snap_trail_r <= trail_run_nxt;
      snap_saw_r   <= saw_ref_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_start = snap_start_r;
  assign snap_ref   = snap_ref_r;
  assign snap_lead  = snap_lead_r;
  assign snap_trail = snap_trail_r;
  assign snap_saw   = snap_saw_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cspan_finish.sv =====
// Final position arithmetic and the result register with its handshake.
// Depends on cspan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cspan_finish #(
  parameter int POSITION_BITS = cspan_pkg::DEF_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     snap_valid,
  input  logic [POSITION_BITS-1:0] snap_start,
  input  logic [POSITION_BITS-1:0] snap_ref,
  input  logic [POSITION_BITS-1:0] snap_lead,
  input  logic [POSITION_BITS-1:0] snap_trail,
  input  logic                     snap_saw,
  output logic                     snap_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cspan_pkg::cspan_out_t    out_data
);
  import cspan_pkg::*;

  logic                     out_valid_r, out_valid_nxt;
  cspan_out_t               out_data_r, out_data_nxt;
  logic [POSITION_BITS-1:0] dec;
  logic [POSITION_BITS-1:0] stop, ubegin, uend;

  // all ones subtracts one when a reference op was seen
  assign dec    = {POSITION_BITS{snap_saw}};
  assign stop   = snap_start + snap_ref + dec;
  assign uend   = snap_start + snap_ref + snap_trail + dec;
  assign ubegin = snap_start - snap_lead;

  assign snap_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = snap_take ? snap_valid : out_valid_r;
    out_data_nxt.ref_stop        = RESULT_BITS'(stop);
    out_data_nxt.unclipped_begin = RESULT_BITS'(ubegin);
    out_data_nxt.unclipped_end   = RESULT_BITS'(uend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/cigar_span_calculator_test.sv =====
// Self-checking testbench for cigar_span_calculator: directed and random CIGAR records.
// Depends on cspan_pkg and the cigar_span_calculator RTL; a scoreboard class predicts each span.
`timescale 1ns / 1ps

module cigar_span_calculator_test;
  import cspan_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;  // far above the slowest legal run
  localparam int unsigned DRAIN_CYCLES = 20;      // two-stage pipe plus snapshot, with margin
  localparam int unsigned HOLD_CYCLES  = 200;     // long receiver hold-off for the fill test
  localparam logic [OP_BITS-1:0] OP_CODE_MAX = 4'hF;

  // Predicts the span of each record from the elements the block accepts and
  // checks every out_ request against the oldest prediction.
  class span_scoreboard;
    cspan_out_t  expected_spans[$];
    int unsigned errors;
    logic [31:0] rec_start;
    logic [31:0] ref_sum;
    logic [31:0] lead_clips;
    logic [31:0] trail_clips;
    bit          in_lead;
    bit          saw_ref;

    function new();
      errors    = 0;
      rec_start = '0;
      clear_sums();
    endfunction

    // The latched start survives a record end; only the sums are cleared.
    function void clear_sums();
      ref_sum     = '0;
      lead_clips  = '0;
      trail_clips = '0;
      in_lead     = 1'b1;
      saw_ref     = 1'b0;
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction

    function void note_element(cspan_in_t elem);
      logic [31:0] len;
      logic [31:0] stop;
      cspan_out_t  span;
      len = {4'd0, elem.op_length};
      if (elem.first_element) begin
        rec_start = elem.start_position;
        clear_sums();
      end
      // Clips extend the leading run while it is open and always the trailing
      // run; anything else (unknown codes too) closes the leading run and
      // restarts the trailing one.
      case (elem.op_code)
        OP_S, OP_H: begin
          if (in_lead) lead_clips = lead_clips + len;
          trail_clips = trail_clips + len;
        end
        default: begin
          in_lead     = 1'b0;
          trail_clips = '0;
        end
      endcase
      case (elem.op_code)
        OP_M, OP_D, OP_N, OP_EQ, OP_X: begin
          ref_sum = ref_sum + len;
          saw_ref = 1'b1;
        end
        default: ;
      endcase
      if (elem.last_element) begin
        stop = rec_start + ref_sum;
        if (saw_ref) stop = stop - 32'd1;
        span.ref_stop        = stop;
        span.unclipped_begin = rec_start - lead_clips;
        span.unclipped_end   = stop + trail_clips;
        expected_spans.push_back(span);
        clear_sums();
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(cspan_out_t got);
      cspan_out_t exp;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_spans.pop_front();
      compare_field("ref_stop", exp.ref_stop, got.ref_stop);
      compare_field("unclipped_begin", exp.unclipped_begin, got.unclipped_begin);
      compare_field("unclipped_end", exp.unclipped_end, got.unclipped_end);
    endfunction
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  cspan_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  cspan_out_t out_data;

  span_scoreboard board = new();

  int unsigned send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  bit          hold_request   = 1'b0;
  int unsigned elements_sent  = 0;
  int unsigned cycle_count    = 0;

  cigar_span_calculator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[cigar_span_calculator] ERROR");
      $finish;
    end
  end

  // Receiver. Values are sampled at the edge before the block updates, so an
  // out_ request counts when out_valid was high and our out_stall was low.
  // A hold-off request from the main flow is counted out here, cycle by cycle.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // One in_ request. valid is raised once and only lowered for idle cycles,
  // so back-to-back requests never see two assignments in one step.
  task automatic send_item(input cspan_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    board.note_element(item);
    elements_sent++;
  endtask

  task automatic send_element(input logic [31:0] start, input logic [OP_BITS-1:0] op,
                              input logic [27:0] len, input int first, input int last);
    cspan_in_t item;
    item.start_position = start;
    item.op_code        = op;
    item.op_length      = len;
    item.first_element  = (first != 0);
    item.last_element   = (last != 0);
    send_item(item);
  endtask

  function automatic logic [31:0] pick_start();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(5);
    if (r < 20) return 32'hFFFF_FFFF - $urandom_range(5);
    return $urandom();
  endfunction

  function automatic logic [27:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 28'($urandom_range(300));
    if (r < 70) return '0;
    if (r < 80) return 28'hFFF_FFFF;
    return 28'($urandom());
  endfunction

  // Body ops: mostly legal codes (clips included, so mid-record clips occur),
  // a few unknown codes.
  function automatic logic [OP_BITS-1:0] pick_body_op();
    if ($urandom_range(99) < 8) return OP_BITS'($urandom_range(OP_X + 1, OP_CODE_MAX));
    return OP_BITS'($urandom_range(OP_M, OP_X));
  endfunction

  // A record of leading clips, a body and trailing clips. About one record in
  // ten gets random marks instead: missing first, restarts, early ends.
  task automatic send_random_record();
    int unsigned n;
    int unsigned lead_n;
    int unsigned trail_n;
    int unsigned i;
    bit          noise;
    logic [31:0] start;
    cspan_in_t   item;
    n       = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    lead_n  = $urandom_range(2);
    trail_n = $urandom_range(2);
    noise   = ($urandom_range(9) == 0);
    start   = pick_start();
    for (i = 0; i < n; i++) begin
      // start_position is junk on later elements; the block must ignore it
      item.start_position = (i == 0) ? start : $urandom();
      if (i < lead_n || i + trail_n >= n)
        item.op_code = $urandom_range(1) ? OP_S : OP_H;
      else
        item.op_code = pick_body_op();
      item.op_length     = pick_length();
      item.first_element = (i == 0);
      item.last_element  = (i == n - 1);
      if (noise) begin
        item.first_element = 1'($urandom_range(1));
        item.last_element  = 1'($urandom_range(1));
      end
      send_item(item);
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target         = elements_sent + n_items;
    while (elements_sent < target) send_random_record();
  endtask

  task automatic run_directed();
    // single-element record, widest start and length: stop wraps past 2^32
    send_element(32'hFFFF_FFFF, OP_M, 28'hFFF_FFFF, 1, 1);
    // all-clip record from zero: begin wraps below zero, stop equals start
    send_element(32'h0000_0000, OP_S, 28'hFFF_FFFF, 1, 1);
    // every op, leading S/H, a clip in the middle, trailing H/S
    send_element(32'd100, OP_S, 28'd5, 1, 0);
    send_element(32'hDEAD_BEEF, OP_H, 28'd3, 0, 0);
    send_element(32'h0, OP_M, 28'd10, 0, 0);
    send_element(32'h0, OP_I, 28'd2, 0, 0);
    send_element(32'h0, OP_S, 28'd4, 0, 0);
    send_element(32'h0, OP_D, 28'd7, 0, 0);
    send_element(32'h0, OP_N, 28'd1, 0, 0);
    send_element(32'h0, OP_EQ, 28'd2, 0, 0);
    send_element(32'h0, OP_X, 28'd3, 0, 0);
    send_element(32'h0, OP_P, 28'd1, 0, 0);
    send_element(32'h0, OP_H, 28'd6, 0, 0);
    send_element(32'h0, OP_S, 28'd2, 0, 1);
    // no first mark: continues with the start latched above
    send_element(32'h5555_5555, OP_M, 28'd5, 0, 1);
    // unknown op alone: no reference, no clips
    send_element(32'h8000_0000, OP_CODE_MAX, 28'd0, 1, 1);
    // unknown op then a zero-length M: reference seen with a zero sum
    send_element(32'h0000_0001, OP_X + 1, 28'h0FF_FFFF, 1, 0);
    send_element(32'hFFFF_FFFF, OP_M, 28'd0, 0, 1);
    // clip, insert, clip: one leading and one trailing run
    send_element(32'h7FFF_FFFF, OP_H, 28'h0AA_AAAA, 1, 0);
    send_element(32'h0, OP_I, 28'h055_5555, 0, 0);
    send_element(32'h0, OP_S, 28'h0FF_FFFF, 0, 1);
  endtask

  initial begin : main_flow
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(0, 0, 300);
    run_phase(84, 0, 300);
    run_phase(0, 84, 300);
    // fill test: receiver holds off while the sender keeps offering requests
    hold_request = 1'b1;
    run_phase(0, 0, 150);
    run_phase(29, 29, 300);
    // close any record a noise pass left open, so the tail produces a span
    send_element(pick_start(), OP_M, pick_length(), 1, 1);
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[cigar_span_calculator] OK");
    end else begin
      $display("[cigar_span_calculator] ERROR");
    end
    $finish;
  end

endmodule

// ===== cigar_span_calculator.f =====
+incdir+hw/rtl
hw/rtl/cspan_pkg.sv
hw/rtl/cspan_accum.sv
hw/rtl/cspan_finish.sv
hw/rtl/cigar_span_calculator.sv
tb/cigar_span_calculator_test.sv
